>>> sv/postfix_boolean_evaluator_unit_defines.svh
// Assertion macros shared by the evaluator RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef POSTFIX_BOOLEAN_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_BOOLEAN_EVALUATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PBE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PBE_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PBE_ASSERT(label, clk, rstn, prop, msg)
`define PBE_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

>>> sv/pbe_pkg.sv
`default_nettype none

package pbe_pkg;

    localparam int PROGRAM_DEPTH_DEF = 64;
    localparam int LEAF_COUNT_DEF    = 64;

    localparam int TOKEN_W      = 7;
    localparam int WORD_INDEX_W = 6;
    localparam int LEAF_W       = 64;
    localparam int PROG_LEN_W   = 7;
    localparam int DEPTH_W      = 7;
    localparam int STACK_SLOTS  = 64;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 8;

    localparam logic [PROG_LEN_W-1:0] PROG_LEN_RESET = 7'd1;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_EVAL = 1'b1;

    localparam logic [TOKEN_W-1:0] TOKEN_AND = 7'd64;
    localparam logic [TOKEN_W-1:0] TOKEN_OR  = 7'd65;
    localparam logic [TOKEN_W-1:0] TOKEN_NOT = 7'd66;

    localparam logic [DEPTH_W-1:0] STACK_FULL = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } pbe_state_t;

    typedef struct packed {
        logic prog_wr;      // write the incoming token into the program store
        logic prog_rd;      // read one program entry
        logic start;        // clear the stack and capture the leaf values
        logic exec;         // execute the token on the store read data
        logic result_load;  // capture match and error into the output register
    } pbe_cmd_t;

endpackage

`default_nettype wire

>>> sv/pbe_ram.sv
`default_nettype none

module pbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/pbe_datapath.sv
`default_nettype none
`include "postfix_boolean_evaluator_unit_defines.svh"

module pbe_datapath #(
    parameter int PROGRAM_DEPTH = pbe_pkg::PROGRAM_DEPTH_DEF,
    parameter int LEAF_COUNT    = pbe_pkg::LEAF_COUNT_DEF,
    localparam int ADDR_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pbe_pkg::pbe_cmd_t            cmd,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    input  wire logic [pbe_pkg::TOKEN_W-1:0]  s_token,
    input  wire logic [pbe_pkg::LEAF_W-1:0]   s_leaf_values,
    output logic                              match,
    output logic                              error
);

    import pbe_pkg::*;

    localparam int LEAF_IDX_W = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;

    logic [TOKEN_W-1:0]     tok;
    logic [LEAF_COUNT-1:0]  leaves_reg, leaves_next;
    logic [STACK_SLOTS-1:0] stack_reg, stack_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic                   fault_reg, fault_next;
    logic                   match_reg, error_reg;
    logic                   top_bit, second_bit, leaf_bit, logic_bit;
    logic                   is_leaf;

    pbe_ram #(
        .WIDTH(TOKEN_W),
        .DEPTH(PROGRAM_DEPTH)
    ) u_prog_store (
        .aclk    (aclk),
        .wr_en   (cmd.prog_wr),
        .wr_addr (wr_addr),
        .wr_data (s_token),
        .rd_en   (cmd.prog_rd),
        .rd_addr (rd_addr),
        .rd_data (tok)
    );

    // Bit 0 of the stack register is the top; a push shifts toward the bottom.
    assign top_bit    = (depth_reg != '0) ? stack_reg[0] : 1'b0;
    assign second_bit = (depth_reg >= DEPTH_W'(2)) ? stack_reg[1] : 1'b0;
    assign is_leaf    = tok < TOKEN_AND;
    assign leaf_bit   = (tok < TOKEN_W'(LEAF_COUNT)) ? leaves_reg[tok[LEAF_IDX_W-1:0]] : 1'b0;
    assign logic_bit  = (tok == TOKEN_AND) ? (top_bit & second_bit) : (top_bit | second_bit);

    always_comb begin
        leaves_next = leaves_reg;
        stack_next  = stack_reg;
        depth_next  = depth_reg;
        fault_next  = fault_reg;
        if (cmd.start) begin
            leaves_next = s_leaf_values[LEAF_COUNT-1:0];
            depth_next  = '0;
            fault_next  = 1'b0;
        end else if (cmd.exec) begin
            priority if (tok == TOKEN_NOT) begin
                stack_next[0] = ~top_bit;
                if (depth_reg == '0) begin
                    depth_next = DEPTH_W'(1);
                    fault_next = 1'b1;
                end
            end else if (tok == TOKEN_AND || tok == TOKEN_OR) begin
                if (depth_reg >= DEPTH_W'(2)) begin
                    stack_next = {1'b0, stack_reg[STACK_SLOTS-1:2], logic_bit};
                    depth_next = depth_reg - DEPTH_W'(1);
                end else begin
                    // Underflow: missing operands read as zero and the result is pushed.
                    stack_next[0] = logic_bit;
                    depth_next    = DEPTH_W'(1);
                    fault_next    = 1'b1;
                end
            end else if (is_leaf) begin
                if (depth_reg >= STACK_FULL) begin
                    fault_next = 1'b1;
                end else begin
                    stack_next = {stack_reg[STACK_SLOTS-2:0], leaf_bit};
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end else begin
                // Unknown opcodes leave the stack alone.
                stack_next = stack_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            fault_reg <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        leaves_reg <= leaves_next;
        stack_reg  <= stack_next;
        if (cmd.result_load) begin
            match_reg <= top_bit;
            error_reg <= fault_reg | (depth_reg == '0);
        end
    end

    assign match = match_reg;
    assign error = error_reg;

    `PBE_NEVER(a_depth_bound, aclk, aresetn, depth_reg > STACK_FULL, "stack depth beyond capacity")
    `PBE_ASSERT(a_start_clears, aclk, aresetn, cmd.start |=> (depth_reg == '0 && !fault_reg), "evaluation did not start from an empty stack")
    `PBE_ASSERT(a_leaf_push, aclk, aresetn, (cmd.exec && is_leaf && depth_reg < STACK_FULL) |=> (depth_reg == $past(depth_reg) + DEPTH_W'(1)), "leaf push did not grow the stack")

endmodule

`default_nettype wire

>>> sv/pbe_ctrl.sv
`default_nettype none
`include "postfix_boolean_evaluator_unit_defines.svh"

module pbe_ctrl #(
    parameter int PROGRAM_DEPTH = pbe_pkg::PROGRAM_DEPTH_DEF,
    localparam int ADDR_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pbe_pkg::PROG_LEN_W-1:0]    cfg_wr_data,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_action,
    input  wire logic [pbe_pkg::WORD_INDEX_W-1:0]  s_word_index,
    output logic                                   s_tready,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output pbe_pkg::pbe_cmd_t                      cmd,
    output logic      [ADDR_W-1:0]                 wr_addr,
    output logic      [ADDR_W-1:0]                 rd_addr
);

    import pbe_pkg::*;

    localparam int CNT_W = $clog2(PROGRAM_DEPTH + 1);

    pbe_state_t            state_reg, state_next;
    logic [PROG_LEN_W-1:0] prog_len_reg, prog_len_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      fetch_cnt_reg, fetch_cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [8:0]            prog_len_wide, len_wide, widx_wide;
    logic                  s_accept, out_free;

    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign prog_len_wide = 9'(prog_len_reg);
    assign len_wide      = (prog_len_wide > 9'(PROGRAM_DEPTH)) ? 9'(PROGRAM_DEPTH) : prog_len_wide;
    assign widx_wide     = 9'(s_word_index);
    assign prog_len_next = cfg_wr_en ? cfg_wr_data : prog_len_reg;

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        fetch_cnt_next = fetch_cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        cmd            = '0;
        wr_addr        = widx_wide[ADDR_W-1:0];
        rd_addr        = fetch_cnt_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_action == ACTION_LOAD && widx_wide < 9'(PROGRAM_DEPTH)) begin
                    cmd.prog_wr = 1'b1;
                end
                if (s_accept && s_action == ACTION_EVAL) begin
                    cmd.start      = 1'b1;
                    len_next       = len_wide[CNT_W-1:0];
                    fetch_cnt_next = '0;
                    if (len_wide == 9'd0) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.prog_rd    = 1'b1;
                        rd_addr        = '0;
                        fetch_cnt_next = CNT_W'(1);
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // The token fetched last cycle executes while the next one is read.
                cmd.exec = 1'b1;
                if (fetch_cnt_reg == len_reg) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.prog_rd    = 1'b1;
                    fetch_cnt_next = fetch_cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prog_len_reg  <= PROG_LEN_RESET;
            len_reg       <= '0;
            fetch_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prog_len_reg  <= prog_len_next;
            len_reg       <= len_next;
            fetch_cnt_reg <= fetch_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `PBE_NEVER(a_fetch_bound, aclk, aresetn, fetch_cnt_reg > len_reg, "fetch count passed program length")
    `PBE_ASSERT(a_no_overwrite, aclk, aresetn, cmd.result_load |-> (!m_tvalid_reg || m_tready), "result word overwritten before it was taken")
    `PBE_ASSERT(a_valid_from_done, aclk, aresetn, (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == ST_DONE), "result raised outside the finish step")

endmodule

`default_nettype wire

>>> sv/postfix_boolean_evaluator_unit.sv
// Load word: accepted while idle, ready again on the next cycle.
// Evaluate word: L = min(program_length, PROGRAM_DEPTH); the L tokens run in ST_RUN, then
// the result word is raised from ST_DONE, later while an earlier result still waits on m_tready.
// s_tready returns with the result, so no new evaluate word is taken while one is in flight.
// Evaluation walks one token per cycle, set by the single read port of the program store.
// Reset (aresetn low, synchronous): idle, no result pending, program_length = 1.
`default_nettype none

module postfix_boolean_evaluator_unit #(
    parameter int PROGRAM_DEPTH = pbe_pkg::PROGRAM_DEPTH_DEF,
    parameter int LEAF_COUNT    = pbe_pkg::LEAF_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pbe_pkg::PROG_LEN_W-1:0]   cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: word_index[5:0], token[12:6], leaf_values[76:13], zero fill[79:77]
    input  wire logic [pbe_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action[0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: match[0], error[1], zero fill[7:2]
    output logic      [pbe_pkg::M_TDATA_W-1:0]    m_tdata
);

    import pbe_pkg::*;

    localparam int ADDR_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

    pbe_cmd_t          cmd;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              match, error;

    pbe_ctrl #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_action     (s_tuser),
        .s_word_index (s_tdata[WORD_INDEX_W-1:0]),
        .s_tready     (s_tready),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    pbe_datapath #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .LEAF_COUNT   (LEAF_COUNT)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .s_token       (s_tdata[WORD_INDEX_W +: TOKEN_W]),
        .s_leaf_values (s_tdata[WORD_INDEX_W + TOKEN_W +: LEAF_W]),
        .match         (match),
        .error         (error)
    );

    assign m_tdata = {{(M_TDATA_W - 2){1'b0}}, error, match};

endmodule

`default_nettype wire

>>> test/postfix_boolean_evaluator_unit_tb.sv
`default_nettype none

module postfix_boolean_evaluator_unit_tb;
    import pbe_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_COUNT = 12;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [PROG_LEN_W-1:0]   cfg_wr_data;
    logic                    s_tvalid;
    logic                    s_tready;
    // s_tdata: word_index[5:0], token[12:6], leaf_values[76:13], zero fill[79:77]
    logic [S_TDATA_W-1:0]    s_tdata;
    // s_tuser: action[0]
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // m_tdata: match[0], error[1], zero fill[7:2]
    logic [M_TDATA_W-1:0]    m_tdata;

    bit steady;
    int stall_cycles;
    int lengths_used;

    class match_scoreboard;
        logic [TOKEN_W-1:0]    program_store [PROGRAM_DEPTH_DEF];
        logic [PROG_LEN_W-1:0] program_length;
        bit                    eval_stack [STACK_SLOTS];
        int                    eval_depth;
        bit                    eval_fault;
        bit [1:0]              pending_verdicts [$];
        int                    failures;
        int                    loads;
        int                    evals;
        int                    error_results;

        function new();
            program_length = PROG_LEN_RESET;
            failures = 0;
            loads = 0;
            evals = 0;
            error_results = 0;
        endfunction

        function void push_bit(bit b);
            if (eval_depth >= STACK_SLOTS) begin
                eval_fault = 1'b1;
            end else begin
                eval_stack[eval_depth] = b;
                eval_depth++;
            end
        endfunction

        function bit pop_bit();
            if (eval_depth == 0) begin
                eval_fault = 1'b1;
                return 1'b0;
            end
            eval_depth--;
            return eval_stack[eval_depth];
        endfunction

        // Returns {error, match} for one walk of the stored program.
        function bit [1:0] evaluate_program(logic [LEAF_W-1:0] leaves);
            int len;
            bit a;
            bit b;
            logic [TOKEN_W-1:0] t;
            len = (program_length > PROGRAM_DEPTH_DEF) ? PROGRAM_DEPTH_DEF : program_length;
            eval_depth = 0;
            eval_fault = 1'b0;
            for (int i = 0; i < len; i++) begin
                t = program_store[i];
                if (t == TOKEN_NOT) begin
                    a = pop_bit();
                    push_bit(~a);
                end else if (t == TOKEN_OR) begin
                    a = pop_bit();
                    b = pop_bit();
                    push_bit(a | b);
                end else if (t == TOKEN_AND) begin
                    a = pop_bit();
                    b = pop_bit();
                    push_bit(a & b);
                end else if (t < LEAF_COUNT_DEF) begin
                    push_bit(leaves[t[5:0]]);
                end
            end
            a = pop_bit();
            return {eval_fault, a};
        endfunction

        function void note_word(logic action, logic [WORD_INDEX_W-1:0] idx,
                                logic [TOKEN_W-1:0] tok, logic [LEAF_W-1:0] leaves);
            if (action == ACTION_LOAD) begin
                program_store[idx] = tok;
                loads++;
            end else begin
                pending_verdicts.push_back(evaluate_program(leaves));
                evals++;
            end
        endfunction

        function void check_word(logic match, logic error);
            bit [1:0] want;
            if (error === 1'b1)
                error_results++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result word with nothing pending: match=%b error=%b",
                         $time, match, error);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (match !== want[0]) begin
                $display("%0t: match mismatch: expected %b, actual %b", $time, want[0], match);
                failures++;
            end
            if (error !== want[1]) begin
                $display("%0t: error mismatch: expected %b, actual %b", $time, want[1], error);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    match_scoreboard sb;

    postfix_boolean_evaluator_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata[0], m_tdata[1]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [LEAF_W-1:0] random_leaves();
        return {$urandom, $urandom};
    endfunction

    // A depth d can still end as a single bit within rem more tokens.
    function automatic bit reachable(int d, int rem);
        if (d >= 1)
            return (d - 1 <= rem) && (d <= STACK_SLOTS);
        return rem >= 1;
    endfunction

    task automatic send_word(logic action, logic [WORD_INDEX_W-1:0] idx,
                             logic [TOKEN_W-1:0] tok, logic [LEAF_W-1:0] leaves);
        while (!steady && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {3'b000, leaves, tok, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_word(action, idx, tok, leaves);
    endtask

    task automatic load_token(logic [WORD_INDEX_W-1:0] idx, logic [TOKEN_W-1:0] tok);
        send_word(ACTION_LOAD, idx, tok, random_leaves());
    endtask

    task automatic eval_leaves(logic [LEAF_W-1:0] leaves);
        send_word(ACTION_EVAL, '0, TOKEN_W'($urandom_range(127)), leaves);
    endtask

    // Waits for the block to go idle, then writes program_length.
    task automatic set_length(logic [PROG_LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.program_length = len;
        lengths_used++;
    endtask

    // Loads a random well-formed postfix program into entries 0..n-1.
    task automatic load_valid_program(int n);
        int depth;
        int nd;
        int rem;
        int r;
        bit ok;
        logic [TOKEN_W-1:0] tok;
        depth = 0;
        for (int i = 0; i < n; i++) begin
            rem = n - i - 1;
            ok = 1'b0;
            for (int tries = 0; tries < 8 && !ok; tries++) begin
                r = $urandom_range(99);
                if (r < 50) begin
                    tok = TOKEN_W'($urandom_range(LEAF_COUNT_DEF - 1));
                    nd = depth + 1;
                    ok = reachable(nd, rem);
                end else if (r < 80) begin
                    tok = $urandom_range(1) ? TOKEN_AND : TOKEN_OR;
                    nd = depth - 1;
                    ok = (depth >= 2) && reachable(nd, rem);
                end else if (r < 92) begin
                    tok = TOKEN_NOT;
                    nd = depth;
                    ok = (depth >= 1) && reachable(nd, rem);
                end else begin
                    tok = TOKEN_W'($urandom_range(127, TOKEN_NOT + 1));
                    nd = depth;
                    ok = reachable(nd, rem);
                end
            end
            if (!ok) begin
                if (depth >= 2 && reachable(depth - 1, rem)) begin
                    tok = $urandom_range(1) ? TOKEN_AND : TOKEN_OR;
                    nd = depth - 1;
                end else if (depth >= 1 && reachable(depth, rem)) begin
                    tok = TOKEN_NOT;
                    nd = depth;
                end else begin
                    tok = TOKEN_W'($urandom_range(LEAF_COUNT_DEF - 1));
                    nd = depth + 1;
                end
            end
            load_token(WORD_INDEX_W'(i), tok);
            depth = nd;
        end
    endtask

    initial begin
        int phase_lengths [PHASE_COUNT];
        int span;
        int budget;
        int phase_items;
        int r;
        logic [LEAF_W-1:0] leaves;

        sb = new();
        steady = 1'b0;
        stall_cycles = 0;
        lengths_used = 1;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= ACTION_LOAD;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset length of one token.
        load_token(0, 7'd0);
        eval_leaves('0);
        eval_leaves('1);
        load_token(0, 7'd63);
        eval_leaves(64'h8000_0000_0000_0000);
        eval_leaves(64'h7FFF_FFFF_FFFF_FFFF);
        // A lone operator pops an empty stack; an unknown opcode leaves it empty.
        load_token(0, TOKEN_NOT);
        eval_leaves(random_leaves());
        load_token(0, TOKEN_AND);
        eval_leaves(random_leaves());
        load_token(0, TOKEN_OR);
        eval_leaves(random_leaves());
        load_token(0, 7'd127);
        eval_leaves(random_leaves());
        set_length(7'd0);
        eval_leaves('1);
        set_length(7'd3);
        load_token(0, 7'd5);
        load_token(1, 7'd9);
        load_token(2, TOKEN_OR);
        eval_leaves(64'h0000_0000_0000_0200);
        load_token(2, TOKEN_AND);
        eval_leaves(64'h0000_0000_0000_0220);
        load_token(1, TOKEN_NOT);
        eval_leaves(64'h0000_0000_0000_0020);

        phase_lengths = '{64, 5, 127, 1, 0, 2, 65, 12, 33, 3, 20, 8};
        phase_lengths[7] = $urandom_range(40, 4);
        phase_lengths[9] = $urandom_range(16, 2);
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_length(PROG_LEN_W'(phase_lengths[p]));
            span = (phase_lengths[p] > PROGRAM_DEPTH_DEF) ? PROGRAM_DEPTH_DEF : phase_lengths[p];
            budget = (span + 30 > 72) ? span + 30 : 72;
            steady = (p == 3);
            phase_items = 0;
            if (span > 0) begin
                load_valid_program(span);
                phase_items += span;
            end
            while (phase_items < budget) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    case ($urandom_range(9))
                        0: leaves = '0;
                        1: leaves = '1;
                        default: leaves = random_leaves();
                    endcase
                    eval_leaves(leaves);
                    phase_items++;
                end else if (r < 70 && span > 0 && (span <= 20 || $urandom_range(3) == 0)) begin
                    load_valid_program(span);
                    phase_items += span;
                end else if (r < 85 && span < PROGRAM_DEPTH_DEF) begin
                    // Stray word outside the running program.
                    load_token(WORD_INDEX_W'($urandom_range(PROGRAM_DEPTH_DEF - 1, span)),
                               TOKEN_W'($urandom_range(127)));
                    phase_items++;
                end else begin
                    // Random token anywhere, which may break the program.
                    load_token(WORD_INDEX_W'($urandom_range(PROGRAM_DEPTH_DEF - 1)),
                               TOKEN_W'($urandom_range(127)));
                    phase_items++;
                end
            end
            steady = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Run moved %0d load words and %0d evaluate words over %0d length settings;",
                 sb.loads, sb.evals, lengths_used);
        $display("%0d results carried the error flag.", sb.error_results);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.failures, sb.outstanding());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/pbe_pkg.sv
sv/pbe_ram.sv
sv/pbe_datapath.sv
sv/pbe_ctrl.sv
sv/postfix_boolean_evaluator_unit.sv
test/postfix_boolean_evaluator_unit_tb.sv
